@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL. Synthesis builds define
// SYNTH, which empties every macro.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Checked only while reset is released.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ sv/cau_pkg.sv @@
// ----------------------------------------------------------------------------
// cau_pkg
// Operation codes and internal lane kinds of the complex arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

  // Operation codes carried on the input tuser field.
  typedef enum logic [2:0] {
    CMD_ADD  = 3'd0,
    CMD_SUB  = 3'd1,
    CMD_MUL  = 3'd2,
    CMD_DIV  = 3'd3,
    CMD_CONJ = 3'd4,
    CMD_MAG  = 3'd5
  } cmd_t;

  // How a transaction is treated after the sum stage.
  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_MUL,
    KIND_DIV,
    KIND_SQRT
  } kind_t;

endpackage

`default_nettype wire

@@ sv/complex_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Pipelined complex ALU on signed fixed-point operands: add, subtract,
// multiply, divide, conjugate and magnitude, with overflow and divide-by-zero flags.
// ----------------------------------------------------------------------------
//  channel   direction  tdata                             tuser
//  in_       slave      lhs_re, lhs_im, rhs_re, rhs_im    cmd
//  out_      master     res_re, res_im                    div_zero, overflow
//
//  One transaction enters per cycle while the output is not stalled; the
//  restoring divider and square root resolve one quotient or root bit per
//  pipeline stage. Products are formed in the first stage.
//  Reset clears only the valid bits of all stages.
//  A stall on the output holds the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module complex_arithmetic_unit
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8,
  localparam int IDW = ((4 * DATA_WIDTH + 7) / 8) * 8,
  localparam int ODW = ((2 * DATA_WIDTH + 7) / 8) * 8
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic [IDW-1:0] in_tdata,   // lhs_re, lhs_im, rhs_re, rhs_im, zero pad
  input  wire logic [2:0]     in_tuser,   // cmd
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic [ODW-1:0]      out_tdata,  // res_re, res_im, zero pad
  output logic [1:0]          out_tuser   // div_zero, overflow
);

  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int PW  = 2 * W;
  localparam int SW  = 2 * W + 1;
  localparam int NW  = SW + F;
  localparam int QRW = W + 2;
  localparam logic [W-1:0]  MAXP    = {1'b0, {(W - 1){1'b1}}};
  localparam logic [W-1:0]  MINN    = {1'b1, {(W - 1){1'b0}}};
  localparam logic [SW-1:0] LIM_POS = SW'(MAXP);
  localparam logic [SW-1:0] LIM_NEG = SW'(MINN);

  // Clamp a sign/magnitude value to W bits; returns {overflow, value}.
  function automatic logic [W:0] sat_fn(input logic neg, input logic [SW-1:0] mag,
                                        input logic big);
    logic          ov;
    logic [W-1:0]  val;
    if (!neg) begin
      ov  = big || (mag > LIM_POS);
      val = ov ? MAXP : mag[W-1:0];
    end else begin
      ov  = big || (mag > LIM_NEG);
      val = ov ? MINN : (~mag[W-1:0] + W'(1));
    end
    return {ov, val};
  endfunction

  logic adv;

  // The whole pipeline moves whenever the output register is free.
  assign adv       = out_tready || !out_tvalid;
  assign in_tready = adv;

  // --------------------------------------------------------------------------
  // Stage A: operand capture and the eight partial products.
  // --------------------------------------------------------------------------
  logic                 a_v_r;
  cmd_t                 a_cmd_r;
  logic signed [W-1:0]  a_a_r, a_b_r, a_c_r, a_d_r;
  logic signed [PW-1:0] a_ac_r, a_bd_r, a_ad_r, a_bc_r, a_cc_r, a_dd_r, a_aa_r, a_bb_r;
  logic signed [W-1:0]  in_a, in_b, in_c, in_d;

  assign in_a = in_tdata[W-1:0];
  assign in_b = in_tdata[2*W-1:W];
  assign in_c = in_tdata[3*W-1:2*W];
  assign in_d = in_tdata[4*W-1:3*W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_cmd_r <= cmd_t'(in_tuser);
      a_a_r   <= in_a;
      a_b_r   <= in_b;
      a_c_r   <= in_c;
      a_d_r   <= in_d;
      a_ac_r  <= in_a * in_c;
      a_bd_r  <= in_b * in_d;
      a_ad_r  <= in_a * in_d;
      a_bc_r  <= in_b * in_c;
      a_cc_r  <= in_c * in_c;
      a_dd_r  <= in_d * in_d;
      a_aa_r  <= in_a * in_a;
      a_bb_r  <= in_b * in_b;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: exact sums per operation, divisor and zero-divisor check.
  // --------------------------------------------------------------------------
  logic                 b_v_r, b_dz_r, b_dz_nxt;
  kind_t                b_kind_r, b_kind_nxt;
  logic signed [SW-1:0] b_re_r, b_im_r, b_re_nxt, b_im_nxt;
  logic [PW-1:0]        b_den_r, b_den_nxt;

  always_comb begin
    b_re_nxt   = '0;
    b_im_nxt   = '0;
    b_dz_nxt   = 1'b0;
    b_kind_nxt = KIND_PASS;
    b_den_nxt  = $unsigned(a_cc_r) + $unsigned(a_dd_r);
    unique case (a_cmd_r)
      CMD_ADD: begin
        b_re_nxt = SW'(a_a_r) + SW'(a_c_r);
        b_im_nxt = SW'(a_b_r) + SW'(a_d_r);
      end
      CMD_SUB: begin
        b_re_nxt = SW'(a_a_r) - SW'(a_c_r);
        b_im_nxt = SW'(a_b_r) - SW'(a_d_r);
      end
      CMD_MUL: begin
        b_re_nxt   = SW'(a_ac_r) - SW'(a_bd_r);
        b_im_nxt   = SW'(a_ad_r) + SW'(a_bc_r);
        b_kind_nxt = KIND_MUL;
      end
      CMD_DIV: begin
        if (a_c_r == '0 && a_d_r == '0) begin
          // Zero divisor: the dividend goes out unchanged.
          b_re_nxt = SW'(a_a_r);
          b_im_nxt = SW'(a_b_r);
          b_dz_nxt = 1'b1;
        end else begin
          b_re_nxt   = SW'(a_ac_r) + SW'(a_bd_r);
          b_im_nxt   = SW'(a_bc_r) - SW'(a_ad_r);
          b_kind_nxt = KIND_DIV;
        end
      end
      CMD_CONJ: begin
        b_re_nxt = SW'(a_a_r);
        b_im_nxt = -SW'(a_b_r);
      end
      CMD_MAG: begin
        b_re_nxt   = SW'(a_aa_r) + SW'(a_bb_r);
        b_kind_nxt = KIND_SQRT;
      end
      default: begin
        b_re_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (adv) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_re_r   <= b_re_nxt;
      b_im_r   <= b_im_nxt;
      b_dz_r   <= b_dz_nxt;
      b_kind_r <= b_kind_nxt;
      b_den_r  <= b_den_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: sign and magnitude; products are scaled back toward zero.
  // --------------------------------------------------------------------------
  logic          c_v_r, c_dz_r, c_neg_re_r, c_neg_im_r;
  kind_t         c_kind_r;
  logic [SW-1:0] c_mag_re_r, c_mag_im_r, c_mag_re_nxt, c_mag_im_nxt;
  logic [PW-1:0] c_den_r;

  always_comb begin
    c_mag_re_nxt = b_re_r[SW-1] ? $unsigned(-b_re_r) : $unsigned(b_re_r);
    c_mag_im_nxt = b_im_r[SW-1] ? $unsigned(-b_im_r) : $unsigned(b_im_r);
    if (b_kind_r == KIND_MUL) begin
      c_mag_re_nxt = c_mag_re_nxt >> F;
      c_mag_im_nxt = c_mag_im_nxt >> F;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (adv) begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_neg_re_r <= b_re_r[SW-1];
      c_neg_im_r <= b_im_r[SW-1];
      c_mag_re_r <= c_mag_re_nxt;
      c_mag_im_r <= c_mag_im_nxt;
      c_dz_r     <= b_dz_r;
      c_kind_r   <= b_kind_r;
      c_den_r    <= b_den_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage D and bit stages: index 0 is the setup stage, index k+1 holds the
  // state after quotient or root bit k.
  // --------------------------------------------------------------------------
  logic           it_v_r      [W+1];
  kind_t          it_kind_r   [W+1];
  logic           it_dz_r     [W+1];
  logic           it_neg_re_r [W+1];
  logic           it_neg_im_r [W+1];
  logic           it_ov_re_r  [W+1];
  logic           it_ov_im_r  [W+1];
  logic [PW-1:0]  it_den_r    [W+1];
  logic [PW-1:0]  it_rem_re_r [W+1];
  logic [PW-1:0]  it_rem_im_r [W+1];
  logic [W-1:0]   it_lo_re_r  [W+1];
  logic [W-1:0]   it_lo_im_r  [W+1];
  logic [W-1:0]   it_q_re_r   [W+1];
  logic [W-1:0]   it_q_im_r   [W+1];
  logic [PW-1:0]  it_s_r      [W+1];
  logic [QRW-1:0] it_srem_r   [W+1];

  logic [NW-1:0]  d_n_re, d_n_im, d_hi_re, d_hi_im;
  logic           d_neg_re_nxt, d_ov_re_nxt, d_ov_im_nxt;
  logic [W-1:0]   d_q_re_nxt, d_q_im_nxt;
  logic [W:0]     d_sat_re, d_sat_im;

  // Setup: scaled numerators, early overflow test and pass-through results.
  always_comb begin
    d_n_re       = NW'(c_mag_re_r) << F;
    d_n_im       = NW'(c_mag_im_r) << F;
    d_hi_re      = d_n_re >> W;
    d_hi_im      = d_n_im >> W;
    d_sat_re     = sat_fn(c_neg_re_r, c_mag_re_r, 1'b0);
    d_sat_im     = sat_fn(c_neg_im_r, c_mag_im_r, 1'b0);
    d_neg_re_nxt = c_neg_re_r;
    d_q_re_nxt   = d_sat_re[W-1:0];
    d_q_im_nxt   = d_sat_im[W-1:0];
    d_ov_re_nxt  = d_sat_re[W];
    d_ov_im_nxt  = d_sat_im[W];
    unique case (c_kind_r)
      KIND_DIV: begin
        // A quotient of more than W bits always saturates.
        d_q_re_nxt  = '0;
        d_q_im_nxt  = '0;
        d_ov_re_nxt = d_hi_re >= NW'(c_den_r);
        d_ov_im_nxt = d_hi_im >= NW'(c_den_r);
      end
      KIND_SQRT: begin
        d_neg_re_nxt = 1'b0;
        d_q_re_nxt   = '0;
        d_q_im_nxt   = '0;
        d_ov_re_nxt  = 1'b0;
        d_ov_im_nxt  = 1'b0;
      end
      default: begin
        d_neg_re_nxt = c_neg_re_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_v_r[0] <= 1'b0;
    end else if (adv) begin
      it_v_r[0] <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it_kind_r[0]   <= c_kind_r;
      it_dz_r[0]     <= c_dz_r;
      it_neg_re_r[0] <= d_neg_re_nxt;
      it_neg_im_r[0] <= c_neg_im_r;
      it_ov_re_r[0]  <= d_ov_re_nxt;
      it_ov_im_r[0]  <= d_ov_im_nxt;
      it_den_r[0]    <= c_den_r;
      it_rem_re_r[0] <= PW'(d_hi_re);
      it_rem_im_r[0] <= PW'(d_hi_im);
      it_lo_re_r[0]  <= d_n_re[W-1:0];
      it_lo_im_r[0]  <= d_n_im[W-1:0];
      it_q_re_r[0]   <= d_q_re_nxt;
      it_q_im_r[0]   <= d_q_im_nxt;
      it_s_r[0]      <= PW'(c_mag_re_r);
      it_srem_r[0]   <= '0;
    end
  end

  for (genvar k = 0; k < W; k++) begin : g_step
    logic [PW-1:0]  t_re, t_im, rem_re_nxt, rem_im_nxt;
    logic           ge_re, ge_im, sge;
    logic [W+3:0]   st, trial;
    logic [W-1:0]   q_re_nxt, q_im_nxt;
    logic [QRW-1:0] srem_nxt;

    // One restoring divide step per lane and one square-root digit step.
    always_comb begin
      t_re       = {it_rem_re_r[k][PW-2:0], it_lo_re_r[k][W-1]};
      t_im       = {it_rem_im_r[k][PW-2:0], it_lo_im_r[k][W-1]};
      ge_re      = t_re >= it_den_r[k];
      ge_im      = t_im >= it_den_r[k];
      st         = {it_srem_r[k], it_s_r[k][PW-1 -: 2]};
      trial      = {2'b00, it_q_re_r[k], 2'b01};
      sge        = st >= trial;
      srem_nxt   = sge ? QRW'(st - trial) : QRW'(st);
      rem_re_nxt = it_rem_re_r[k];
      rem_im_nxt = it_rem_im_r[k];
      q_re_nxt   = it_q_re_r[k];
      q_im_nxt   = it_q_im_r[k];
      unique case (it_kind_r[k])
        KIND_DIV: begin
          rem_re_nxt = ge_re ? (t_re - it_den_r[k]) : t_re;
          rem_im_nxt = ge_im ? (t_im - it_den_r[k]) : t_im;
          q_re_nxt   = {it_q_re_r[k][W-2:0], ge_re};
          q_im_nxt   = {it_q_im_r[k][W-2:0], ge_im};
        end
        KIND_SQRT: begin
          q_re_nxt = {it_q_re_r[k][W-2:0], sge};
        end
        default: begin
          q_re_nxt = it_q_re_r[k];
        end
      endcase
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        it_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        it_v_r[k+1] <= it_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        it_kind_r[k+1]   <= it_kind_r[k];
        it_dz_r[k+1]     <= it_dz_r[k];
        it_neg_re_r[k+1] <= it_neg_re_r[k];
        it_neg_im_r[k+1] <= it_neg_im_r[k];
        it_ov_re_r[k+1]  <= it_ov_re_r[k];
        it_ov_im_r[k+1]  <= it_ov_im_r[k];
        it_den_r[k+1]    <= it_den_r[k];
        it_rem_re_r[k+1] <= rem_re_nxt;
        it_rem_im_r[k+1] <= rem_im_nxt;
        it_lo_re_r[k+1]  <= it_lo_re_r[k] << 1;
        it_lo_im_r[k+1]  <= it_lo_im_r[k] << 1;
        it_q_re_r[k+1]   <= q_re_nxt;
        it_q_im_r[k+1]   <= q_im_nxt;
        it_s_r[k+1]      <= it_s_r[k] << 2;
        it_srem_r[k+1]   <= srem_nxt;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage E: final saturation of quotient and root, output register.
  // --------------------------------------------------------------------------
  logic         e_v_r, e_dz_r, e_ov_r, e_ov_nxt;
  logic [W-1:0] e_re_r, e_im_r, e_re_nxt, e_im_nxt;
  logic [W:0]   e_sat_re, e_sat_im;

  always_comb begin
    e_sat_re = sat_fn(it_neg_re_r[W], SW'(it_q_re_r[W]), it_ov_re_r[W]);
    e_sat_im = sat_fn(it_neg_im_r[W], SW'(it_q_im_r[W]), it_ov_im_r[W]);
    e_re_nxt = it_q_re_r[W];
    e_im_nxt = it_q_im_r[W];
    e_ov_nxt = it_ov_re_r[W] || it_ov_im_r[W];
    unique case (it_kind_r[W])
      KIND_DIV: begin
        e_re_nxt = e_sat_re[W-1:0];
        e_im_nxt = e_sat_im[W-1:0];
        e_ov_nxt = e_sat_re[W] || e_sat_im[W];
      end
      KIND_SQRT: begin
        e_re_nxt = e_sat_re[W-1:0];
        e_ov_nxt = e_sat_re[W];
      end
      default: begin
        e_re_nxt = it_q_re_r[W];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else if (adv) begin
      e_v_r <= it_v_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_re_r <= e_re_nxt;
      e_im_r <= e_im_nxt;
      e_dz_r <= it_dz_r[W];
      e_ov_r <= e_ov_nxt;
    end
  end

  assign out_tvalid = e_v_r;
  assign out_tdata  = ODW'({e_im_r, e_re_r});
  assign out_tuser  = {e_ov_r, e_dz_r};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASSERT_RST(a_dz_no_ovf, clk, rst_n, out_tvalid && out_tuser[0] |-> !out_tuser[1], "div_zero result flagged overflow")
  `ASSERT_RST(a_dz_pass, clk, rst_n, it_v_r[W] && it_dz_r[W] |-> it_kind_r[W] == KIND_PASS, "zero divisor entered the divider")
  `ASSERT_RST(a_sqrt_im, clk, rst_n, it_v_r[W] && it_kind_r[W] == KIND_SQRT |-> it_q_im_r[W] == '0 && !it_ov_im_r[W], "magnitude imaginary lane not clear")
  `ASSERT_ALWAYS(a_rst_clear, clk, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

`default_nettype wire
